### rtl/load_average_priority_recompute_unit_assert.svh
// Assertion macros for the load average priority recompute unit.
`ifndef LOAD_AVERAGE_PRIORITY_RECOMPUTE_UNIT_ASSERT_SVH
`define LOAD_AVERAGE_PRIORITY_RECOMPUTE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LAPR_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m: same-cycle check failed");
`define LAPR_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%m: next-cycle check failed");
`else
`define LAPR_ASSERT_IMP(label, clk, rst, a, c)
`define LAPR_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

### rtl/lapr_pkg.sv
// ----------------------------------------------------------------------------
// lapr_pkg
// Types and constants for the load average priority recompute unit.
// ----------------------------------------------------------------------------
`default_nettype none
package lapr_pkg;
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic [7:0] BASE_QUANTUM_RESET = 8'd10;
  localparam logic [6:0] PRIO_MAX = 7'd127;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_AVG,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_t;
endpackage
`default_nettype wire

### rtl/load_average_priority_recompute_unit.sv
// ----------------------------------------------------------------------------
// load_average_priority_recompute_unit
// Slot table with windowed load average and decay-usage priority recompute.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/stall): operation 0 writes one slot entry. Operation
//   1 is a tick: ready slots 1..NUM_SLOTS-1 are counted one slot per
//   cycle, the count enters the load window, and the average is found with
//   a shared restoring divider (one quotient bit per cycle). Then each slot
//   1..NUM_SLOTS-1 gets one record: a load step, the divider steps for
//   usage*avg/(2*avg+1), and an emit step that presents the record.
//   Output channel (valid/stall): one record is held in the output register;
//   while stall is high the sequencer waits and the record does not change.
//   in_stall is high while a tick is in progress.
//   Config channel (valid/ready): base_quantum, always ready, write it idle.
//   Reset (rst, synchronous): table, window and base_quantum (10) cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "load_average_priority_recompute_unit_assert.svh"
module load_average_priority_recompute_unit #(
  parameter int NUM_SLOTS  = 16,
  parameter int WINDOW_LEN = 60
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        operation,
  input  wire  [3:0] slot,
  input  wire        ready_req,
  input  wire  [6:0] base_priority,
  input  wire signed [5:0] external_priority,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [3:0] out_slot,
  output logic [6:0] priority_res,
  output logic [7:0] recent_usage,
  output logic [8:0] quantum,
  output logic       requeue,
  output logic [3:0] load_average,
  output logic       last,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [7:0] cfg_data
);
  import lapr_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FW = $clog2(WINDOW_LEN + 1);
  localparam int TW = $clog2(15 * WINDOW_LEN + 1);
  localparam int DW = 16;  // shared divider dividend width
  localparam int CW = 5;   // divider step counter

  // slot table
  logic       slot_ready  [NUM_SLOTS];
  logic [6:0] slot_bprio  [NUM_SLOTS];
  logic [5:0] slot_ext    [NUM_SLOTS];
  logic [7:0] slot_usage  [NUM_SLOTS];
  // load window memory, valid by fill count
  logic [3:0] load_history [WINDOW_LEN];
  logic [TW-1:0] window_total;
  logic [WW-1:0] window_position;
  logic [FW-1:0] samples_filled;

  logic [7:0] base_quantum;
  state_t state, state_next;
  logic [SW-1:0] idx;
  logic [3:0] load_cnt;
  logic [3:0] old_sample;
  logic [3:0] avg;
  // divider
  logic [DW-1:0] dvd;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] step;
  logic          div_avg;  // dividing for the average rather than a slot

  logic accept_in, out_done;
  logic [DW:0] rem_shift;
  logic [DW:0] rem_trial;
  logic [TW-1:0] total_new;

  assign cfg_ready = 1'b1;
  assign accept_in = in_valid && !in_stall;
  assign out_done  = out_valid && !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign rem_shift = {rem, dvd[DW-1]};
  assign rem_trial = rem_shift - {1'b0, dvs};
  assign total_new = window_total - TW'(old_sample) + TW'(load_cnt);

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept_in && operation == OP_TICK) state_next = ST_COUNT;
      ST_COUNT: if (idx == SW'(NUM_SLOTS - 1)) state_next = ST_AVG;
      ST_AVG:   state_next = ST_DIV;
      ST_LOAD:  state_next = ST_DIV;
      ST_DIV:   if (step == CW'(DW - 1)) state_next = div_avg ? ST_LOAD : ST_EMIT;
      ST_EMIT: begin
        if (out_done) state_next = last ? ST_IDLE : ST_LOAD;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    logic signed [9:0] r;
    logic signed [9:0] p;
    logic [7:0] rc;
    if (rst) begin
      base_quantum <= BASE_QUANTUM_RESET;
      window_total <= '0;
      window_position <= '0;
      samples_filled <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_ready[i] <= 1'b0;
        slot_bprio[i] <= '0;
        slot_ext[i]   <= '0;
        slot_usage[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) base_quantum <= cfg_data;
      if (out_done) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          idx <= SW'(1);
          load_cnt <= '0;
          if (accept_in && operation == OP_SET && 32'(slot) < NUM_SLOTS) begin
            slot_ready[SW'(slot)] <= ready_req;
            slot_bprio[SW'(slot)] <= base_priority;
            slot_ext[SW'(slot)]   <= external_priority;
          end
        end
        ST_COUNT: begin
          if (slot_ready[idx] && load_cnt != 4'd15) load_cnt <= load_cnt + 4'd1;
          idx <= idx + SW'(1);
          old_sample <= (32'(samples_filled) == WINDOW_LEN) ?
                        load_history[window_position] : 4'd0;
        end
        ST_AVG: begin
          load_history[window_position] <= load_cnt;
          window_total <= total_new;
          window_position <= (32'(window_position) == WINDOW_LEN - 1) ? '0
                             : window_position + WW'(1);
          dvd <= DW'(total_new);
          dvs <= (32'(samples_filled) < WINDOW_LEN) ? DW'(samples_filled) + DW'(1)
                                                    : DW'(samples_filled);
          if (32'(samples_filled) < WINDOW_LEN) samples_filled <= samples_filled + FW'(1);
          rem <= '0;
          step <= '0;
          div_avg <= 1'b1;
          idx <= SW'(1);
        end
        ST_LOAD: begin
          dvd <= DW'(avg) * DW'(slot_usage[idx]);
          dvs <= DW'({avg, 1'b1});
          rem <= '0;
          step <= '0;
          div_avg <= 1'b0;
        end
        ST_DIV: begin
          // one restoring quotient bit per cycle
          if (!rem_trial[DW]) begin
            rem <= rem_trial[DW-1:0];
            dvd <= {dvd[DW-2:0], 1'b1};
          end else begin
            rem <= rem_shift[DW-1:0];
            dvd <= {dvd[DW-2:0], 1'b0};
          end
          step <= step + CW'(1);
          if (step == CW'(DW - 1) && div_avg) begin
            avg <= (({dvd[DW-2:0], !rem_trial[DW]}) > DW'(15)) ? 4'd15
                   : {dvd[2:0], !rem_trial[DW]};
          end
          if (step == CW'(DW - 1) && !div_avg) begin
            r = 10'($signed({1'b0, dvd[7:0], !rem_trial[DW]}))
                + 10'($signed(slot_ext[idx]));
            if (r < 0) rc = 8'd0;
            else if (r > 10'sd255) rc = 8'd255;
            else rc = r[7:0];
            p = 10'($signed({3'b0, slot_bprio[idx]})) + 10'($signed({slot_ext[idx], 1'b0}))
                + 10'($signed({2'b0, rc}));
            slot_usage[idx] <= rc;
            out_slot <= 4'(idx);
            recent_usage <= rc;
            quantum <= 9'(base_quantum) + 9'(rc);
            requeue <= slot_ready[idx];
            load_average <= avg;
            last <= (idx == SW'(NUM_SLOTS - 1));
            if (p < 0) priority_res <= '0;
            else if (p > 10'sd127) priority_res <= PRIO_MAX;
            else priority_res <= p[6:0];
            out_valid <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_done) idx <= idx + SW'(1);
        end
        default: ;
      endcase
    end
  end

  `LAPR_ASSERT_IMP(a_no_accept_busy, clk, rst, state != ST_IDLE, in_stall)
  `LAPR_ASSERT_IMP(a_valid_in_emit, clk, rst, out_valid, state == ST_EMIT)
  `LAPR_ASSERT_NXT(a_last_idle, clk, rst, out_done && last, state == ST_IDLE)
  `LAPR_ASSERT_IMP(a_avg_div_nz, clk, rst, state == ST_DIV, dvs != '0)
endmodule
`default_nettype wire
